// ===== rtl/pwir_pkg.sv =====
// Shared types and constants of the pulse-width IR frame receiver.
`timescale 1ns / 1ps

package pwir_pkg;

  localparam int unsigned PulseW   = 16;
  localparam int unsigned TimerW   = 28;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 28;

  localparam logic [PulseW-1:0] PulseMax = '1;
  localparam logic [TimerW-1:0] TimerMax = '1;

  localparam logic              ActiveLevelRst   = 1'b0;
  localparam logic [PulseW-1:0] BitThresholdRst  = 16'd450;
  localparam logic [PulseW-1:0] SyncThresholdRst = 16'd1500;
  localparam logic [ByteW-1:0]  MaxLengthRst     = 8'd255;
  localparam logic [TimerW-1:0] TimeoutTicksRst  = 28'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVE_LEVEL   = 3'd0,
    CFG_BIT_THRESHOLD  = 3'd1,
    CFG_SYNC_THRESHOLD = 3'd2,
    CFG_MAX_LENGTH     = 3'd3,
    CFG_TIMEOUT_TICKS  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_LEN_ERR  = 2'd1,
    KIND_TIMEOUT  = 2'd2
  } kind_e;

  typedef struct packed {
    logic              active_level;
    logic [PulseW-1:0] bit_threshold;
    logic [PulseW-1:0] sync_threshold;
    logic [ByteW-1:0]  max_length;
    logic [TimerW-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
    logic [ByteW-1:0] frame_length;
  } res_t;

endpackage

// ===== rtl/pulse_width_ir_frame_receiver_top.sv =====
// Top level of the pulse-width IR frame receiver.
`timescale 1ns / 1ps

// Pulse-width IR frame receiver. Feed one receiver-line sample per tick on the
// rx_level word channel; each accepted sample is handled in the cycle it is
// taken, so the block sustains one sample per clock, set by the single pass
// of comparators and counters between the sample port and the result
// register. A pulse longer than sync_threshold opens a frame; shorter pulses
// are bits, MSB first, 0 below bit_threshold. The first byte is the declared
// length; zero or above max_length yields a length-error word and a return to
// hunting. Each payload byte comes out as a word, the last one flagged. With
// timeout_ticks nonzero, an inactive tick after that many listening ticks
// yields a timeout word. Results pass through an output register backed by a
// one-word skid stage: sample intake stalls only when both are full.
// Configuration writes are taken every cycle and should be made while idle.
module pulse_width_ir_frame_receiver_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          rx_level_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    kind_o,
  output logic [pwir_pkg::ByteW-1:0]    data_byte_o,
  output logic                          last_byte_o,
  output logic [pwir_pkg::ByteW-1:0]    frame_length_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pwir_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pwir_pkg::CfgDataW-1:0] cfg_data_i
);

  pwir_pkg::cfg_t cfg;
  pwir_pkg::res_t res;
  pwir_pkg::res_t out_word;
  logic           res_valid;
  logic           space;
  logic           take;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  // take a sample whenever the result buffer can still absorb a word
  assign in_ready_o = space;
  assign take       = in_valid_i & space;

  pwir_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pwir_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .take_i      (take),
    .rx_level_i  (rx_level_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pwir_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_word)
  );

  assign kind_o         = out_word.kind;
  assign data_byte_o    = out_word.data_byte;
  assign last_byte_o    = out_word.last_byte;
  assign frame_length_o = out_word.frame_length;

endmodule

// ===== rtl/pwir_cfg.sv =====
// Configuration register file of the pulse-width IR frame receiver.
`timescale 1ns / 1ps

module pwir_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [pwir_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pwir_pkg::CfgDataW-1:0]  cfg_data_i,
  output pwir_pkg::cfg_t                 cfg_o
);

  pwir_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pwir_pkg::CFG_ACTIVE_LEVEL:   cfg_d.active_level   = cfg_data_i[0];
        pwir_pkg::CFG_BIT_THRESHOLD:  cfg_d.bit_threshold  = cfg_data_i[pwir_pkg::PulseW-1:0];
        pwir_pkg::CFG_SYNC_THRESHOLD: cfg_d.sync_threshold = cfg_data_i[pwir_pkg::PulseW-1:0];
        pwir_pkg::CFG_MAX_LENGTH:     cfg_d.max_length     = cfg_data_i[pwir_pkg::ByteW-1:0];
        pwir_pkg::CFG_TIMEOUT_TICKS:  cfg_d.timeout_ticks  = cfg_data_i[pwir_pkg::TimerW-1:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_level   <= pwir_pkg::ActiveLevelRst;
      cfg_q.bit_threshold  <= pwir_pkg::BitThresholdRst;
      cfg_q.sync_threshold <= pwir_pkg::SyncThresholdRst;
      cfg_q.max_length     <= pwir_pkg::MaxLengthRst;
      cfg_q.timeout_ticks  <= pwir_pkg::TimeoutTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/pwir_core.sv =====
// Pulse measurement, bit assembly and frame tracking, one sample per cycle while take_i is high.
`timescale 1ns / 1ps

module pwir_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pwir_pkg::cfg_t cfg_i,
  input  logic           take_i,
  input  logic           rx_level_i,
  output logic           res_valid_o,
  output pwir_pkg::res_t res_o
);

  localparam int unsigned PulseW = pwir_pkg::PulseW;
  localparam int unsigned TimerW = pwir_pkg::TimerW;
  localparam int unsigned ByteW  = pwir_pkg::ByteW;

  logic              in_pulse_d, in_pulse_q;
  logic [PulseW-1:0] pulse_ticks_d, pulse_ticks_q;
  logic              synced_d, synced_q;
  logic [ByteW-1:0]  shift_byte_d, shift_byte_q;
  logic [2:0]        bits_taken_d, bits_taken_q;
  logic              header_seen_d, header_seen_q;
  logic [ByteW-1:0]  expected_d, expected_q;
  logic [ByteW-1:0]  received_d, received_q;
  logic [TimerW-1:0] idle_timer_d, idle_timer_q;

  logic             active;
  logic [ByteW-1:0] new_byte;
  logic [ByteW-1:0] received_inc;

  assign active       = (rx_level_i == cfg_i.active_level);
  assign new_byte     = {shift_byte_q[ByteW-2:0],
                         (pulse_ticks_q >= cfg_i.bit_threshold)};
  assign received_inc = received_q + 8'd1;

  always_comb begin
    in_pulse_d    = in_pulse_q;
    pulse_ticks_d = pulse_ticks_q;
    synced_d      = synced_q;
    shift_byte_d  = shift_byte_q;
    bits_taken_d  = bits_taken_q;
    header_seen_d = header_seen_q;
    expected_d    = expected_q;
    received_d    = received_q;
    idle_timer_d  = idle_timer_q;
    res_valid_o   = 1'b0;
    res_o         = '{kind: pwir_pkg::KIND_BYTE, data_byte: '0, last_byte: 1'b0,
                      frame_length: '0};

    if (take_i) begin
      if (idle_timer_q != pwir_pkg::TimerMax) begin
        idle_timer_d = idle_timer_q + 28'd1;
      end

      if (active) begin
        in_pulse_d = 1'b1;
        if (!in_pulse_q) begin
          pulse_ticks_d = 16'd1;
        end else if (pulse_ticks_q != pwir_pkg::PulseMax) begin
          pulse_ticks_d = pulse_ticks_q + 16'd1;
        end
      end else if (in_pulse_q) begin
        in_pulse_d    = 1'b0;
        pulse_ticks_d = '0;
        if (pulse_ticks_q > cfg_i.sync_threshold) begin
          synced_d      = 1'b1;
          shift_byte_d  = '0;
          bits_taken_d  = '0;
          header_seen_d = 1'b0;
          expected_d    = '0;
          received_d    = '0;
        end else if (synced_q) begin
          if (bits_taken_q != 3'd7) begin
            shift_byte_d = new_byte;
            bits_taken_d = bits_taken_q + 3'd1;
          end else begin
            shift_byte_d = '0;
            bits_taken_d = '0;
            if (!header_seen_q) begin
              if (new_byte == '0 || new_byte > cfg_i.max_length) begin
                res_valid_o        = 1'b1;
                res_o.kind         = pwir_pkg::KIND_LEN_ERR;
                res_o.frame_length = new_byte;
                synced_d           = 1'b0;
                expected_d         = '0;
                received_d         = '0;
                idle_timer_d       = '0;
              end else begin
                header_seen_d = 1'b1;
                expected_d    = new_byte;
                received_d    = '0;
              end
            end else begin
              res_valid_o        = 1'b1;
              res_o.data_byte    = new_byte;
              res_o.frame_length = expected_q;
              received_d         = received_inc;
              if (received_inc == expected_q) begin
                // frame complete: flag the byte and go back to hunting
                res_o.last_byte = 1'b1;
                synced_d        = 1'b0;
                header_seen_d   = 1'b0;
                expected_d      = '0;
                received_d      = '0;
                idle_timer_d    = '0;
              end
            end
          end
        end
      end else if (cfg_i.timeout_ticks != '0 && idle_timer_q >= cfg_i.timeout_ticks) begin
        res_valid_o   = 1'b1;
        res_o.kind    = pwir_pkg::KIND_TIMEOUT;
        synced_d      = 1'b0;
        shift_byte_d  = '0;
        bits_taken_d  = '0;
        header_seen_d = 1'b0;
        expected_d    = '0;
        received_d    = '0;
        idle_timer_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pulse_q    <= 1'b0;
      pulse_ticks_q <= '0;
      synced_q      <= 1'b0;
      shift_byte_q  <= '0;
      bits_taken_q  <= '0;
      header_seen_q <= 1'b0;
      expected_q    <= '0;
      received_q    <= '0;
      idle_timer_q  <= '0;
    end else begin
      in_pulse_q    <= in_pulse_d;
      pulse_ticks_q <= pulse_ticks_d;
      synced_q      <= synced_d;
      shift_byte_q  <= shift_byte_d;
      bits_taken_q  <= bits_taken_d;
      header_seen_q <= header_seen_d;
      expected_q    <= expected_d;
      received_q    <= received_d;
      idle_timer_q  <= idle_timer_d;
    end
  end

  // a frame in progress always has a declared length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    header_seen_q |-> (expected_q != '0 && synced_q))
    else $error("header seen without a valid length");

  // an out-of-pulse sample leaves no pulse count behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_pulse_q |-> (pulse_ticks_q == '0))
    else $error("pulse count left over outside a pulse");

  // no payload count outside a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !header_seen_q |-> (received_q == '0))
    else $error("payload count outside a frame");

endmodule

// ===== rtl/pwir_skid.sv =====
// Output register with a skid stage for the receiver's result words.
`timescale 1ns / 1ps

module pwir_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pwir_pkg::res_t push_data_i,
  output logic           space_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pwir_pkg::res_t out_data_o
);

  logic           out_valid_d, out_valid_q;
  logic           skid_valid_d, skid_valid_q;
  pwir_pkg::res_t out_d, out_q;
  pwir_pkg::res_t skid_d, skid_q;
  logic           pop;

  assign pop = out_valid_q & out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = push_i;
        if (push_i) begin
          skid_d = push_data_i;
        end
      end else begin
        out_valid_d = push_i;
        if (push_i) begin
          out_d = push_data_i;
        end
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign space_o     = ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // the skid stage only fills behind a held output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word without an output word");

  // never push into a full buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("push into a full buffer");

  // a stalled skid word moves to the output once the output drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && pop) |=> (out_valid_q && out_q == $past(skid_q)))
    else $error("skid word lost on drain");

endmodule
